@@ hdl/wsth_pkg.sv @@
`default_nettype none
package wsth_pkg;

  // table size; ids and counts are reported in five bits whatever the size
  localparam int MAX_WINDOWS = 16;
  localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int ID_W = 5;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_WINDOWS - 1);
  localparam logic [ID_W-1:0] COUNT_MAX = {ID_W{1'b1}};

  // operation codes carried in the func field
  localparam logic [1:0] FUNC_CREATE  = 2'd0;
  localparam logic [1:0] FUNC_DESTROY = 2'd1;
  localparam logic [1:0] FUNC_FOCUS   = 2'd2;
  localparam logic [1:0] FUNC_HIT     = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [4:0]         window_num;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        size_w;
    logic [14:0]        size_h;
  } in_item_t;

  typedef struct packed {
    logic [4:0] answer_id;
    logic       success;
    logic [4:0] focus_id;
    logic [4:0] open_windows;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        width;
    logic [14:0]        height;
  } rect_t;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CREATE,
    OP_CREATE_FAIL,
    OP_DESTROY,
    OP_FOCUS,
    OP_HIT,
    OP_MISS
  } dp_op_t;

  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic [IDX_W-1:0] idx;
    dp_op_t           op;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       slot_free;
    logic       hit;
    logic       out_free;
  } stat_t;

endpackage
`default_nettype wire

@@ hdl/wsth_ctrl.sv @@
`default_nettype none
module wsth_ctrl import wsth_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CREATE,
    ST_HIT,
    ST_HIT_LAST,
    ST_RESULT
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.idx      = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat.func)
          FUNC_CREATE: begin
            cnt_nxt   = '0;
            state_nxt = ST_CREATE;
          end
          FUNC_DESTROY: begin
            cmd.op    = OP_DESTROY;
            state_nxt = ST_RESULT;
          end
          FUNC_FOCUS: begin
            cmd.op    = OP_FOCUS;
            state_nxt = ST_RESULT;
          end
          default: begin
            cnt_nxt   = LAST_IDX;
            state_nxt = ST_HIT;
          end
        endcase
      end
      ST_CREATE: begin
        // lowest free slot wins
        if (stat.slot_free) begin
          cmd.op    = OP_CREATE;
          state_nxt = ST_RESULT;
        end else if (cnt_r == LAST_IDX) begin
          cmd.op    = OP_CREATE_FAIL;
          state_nxt = ST_RESULT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_HIT: begin
        // read slot cnt while the slot read last cycle is compared
        cmd.rd_en = 1'b1;
        if (stat.hit) begin
          cmd.op    = OP_HIT;
          state_nxt = ST_RESULT;
        end else if (cnt_r == '0) begin
          state_nxt = ST_HIT_LAST;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_HIT_LAST: begin
        cmd.op    = stat.hit ? OP_HIT : OP_MISS;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/wsth_dp.sv @@
`default_nettype none
module wsth_dp import wsth_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_data,
  input  wire cmd_t     cmd,
  output stat_t         stat,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  function automatic logic [ID_W-1:0] id_of(input logic [IDX_W-1:0] idx);
    id_of = ID_W'(32'(idx) + 32'd1);
  endfunction

  in_item_t               item_r;
  logic [MAX_WINDOWS-1:0] used_r;
  logic [ID_W-1:0]        focused_r;
  logic [ID_W-1:0]        open_r;
  rect_t                  rect_mem [MAX_WINDOWS];
  rect_t                  rd_data_r;
  logic [IDX_W-1:0]       rd_slot_r;
  logic                   rd_used_r;
  logic                   rd_pend_r;
  logic [ID_W-1:0]        ans_r;
  logic                   ok_r;
  out_item_t              out_r;
  logic                   out_valid_r;

  logic [IDX_W-1:0] num_idx;
  logic             num_hit;
  logic             out_free;
  logic             inside_x, inside_y;
  logic signed [17:0] px, py, x0, y0, x1, y1;

  // window number names a used slot
  assign num_idx = IDX_W'(item_r.window_num - 5'd1);
  assign num_hit = (item_r.window_num != '0) &&
                   (32'(item_r.window_num) <= MAX_WINDOWS) && used_r[num_idx];

  // half-open containment, exact in 18 bits
  assign px = 18'(item_r.pos_x);
  assign py = 18'(item_r.pos_y);
  assign x0 = 18'(rd_data_r.left);
  assign y0 = 18'(rd_data_r.top);
  assign x1 = x0 + $signed({3'b000, rd_data_r.width});
  assign y1 = y0 + $signed({3'b000, rd_data_r.height});
  assign inside_x = (px >= x0) && (px < x1);
  assign inside_y = (py >= y0) && (py < y1);

  assign out_free = !out_valid_r || !out_stall;

  assign stat.func      = item_r.func;
  assign stat.slot_free = !used_r[cmd.idx];
  assign stat.hit       = rd_pend_r && rd_used_r && inside_x && inside_y;
  assign stat.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // table state and handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      focused_r   <= '0;
      open_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd_en;
      case (cmd.op)
        OP_CREATE: begin
          used_r[cmd.idx] <= 1'b1;
          focused_r       <= id_of(cmd.idx);
          if (open_r != COUNT_MAX) begin
            open_r <= open_r + 1'b1;
          end
        end
        OP_DESTROY: begin
          if (num_hit) begin
            used_r[num_idx] <= 1'b0;
            if (open_r != '0) begin
              open_r <= open_r - 1'b1;
            end
            if (focused_r == item_r.window_num) begin
              focused_r <= '0;
            end
          end
        end
        OP_FOCUS: begin
          if (num_hit) begin
            focused_r <= item_r.window_num;
          end
        end
        default: begin
        end
      endcase
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, rectangle store and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.op == OP_CREATE) begin
      rect_mem[cmd.idx] <= '{left: item_r.pos_x, top: item_r.pos_y,
                             width: item_r.size_w, height: item_r.size_h};
    end
    if (cmd.rd_en) begin
      rd_data_r <= rect_mem[cmd.idx];
      rd_used_r <= used_r[cmd.idx];
      rd_slot_r <= cmd.idx;
    end
    case (cmd.op)
      OP_CREATE: begin
        ans_r <= id_of(cmd.idx);
        ok_r  <= 1'b1;
      end
      OP_DESTROY, OP_FOCUS: begin
        ans_r <= '0;
        ok_r  <= num_hit;
      end
      OP_HIT: begin
        ans_r <= id_of(rd_slot_r);
        ok_r  <= 1'b1;
      end
      OP_CREATE_FAIL, OP_MISS: begin
        ans_r <= '0;
        ok_r  <= 1'b0;
      end
      default: begin
      end
    endcase
    if (cmd.out_load) begin
      out_r.answer_id    <= ans_r;
      out_r.success      <= ok_r;
      out_r.focus_id     <= focused_r;
      out_r.open_windows <= open_r;
    end
  end

endmodule
`default_nettype wire

@@ hdl/window_slot_table_hit_test_core.sv @@
`default_nettype none
// Window slot table with hit test.
// Input channel in_valid / in_stall / in_data carries one operation item:
// create, destroy, set focus or hit test. Output channel out_valid /
// out_stall / out_data returns exactly one result item per operation, in order.
// One item is worked on at a time; in_stall is high from acceptance until the
// result has been moved into the output register.
// Create tests one slot per cycle, from slot 0 upward, and takes the lowest free
// slot. Hit test scans from the highest slot downward and answers with the first
// used slot whose rectangle contains the point, or a miss; the scan reads the
// rectangle store one slot per cycle through its single registered read port.
// The next item is accepted once the result is in the output register.
// When the receiver stalls, the finished item waits in the output register and
// a new item is still taken and worked on; its result is held until the output
// register frees.
// Synchronous active-low reset empties the table, clears focus and the open
// count and drops any pending result. Rectangles are not cleared: the scan reads
// unused slots too, but their rectangles never count as a hit.
module window_slot_table_hit_test_core import wsth_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: dispatch, slot scans, result hand-off
  wsth_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // slot table, rectangle store, containment compare and output register
  wsth_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
